// ----- design/pixel_mask_collision_core_assert.svh -----
// Assertion macros used by the checker file of the collision core.
// Each macro expands to one labeled concurrent assertion, sampled on the
// rising clock edge and disabled while the reset is asserted.
`ifndef PIXEL_MASK_COLLISION_CORE_ASSERT_SVH
`define PIXEL_MASK_COLLISION_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMC_ASSERT_SAME(LBL, CK, RN, ANTE, CONS, MSG) \
    LBL: assert property (@(posedge CK) disable iff (!RN) (ANTE) |-> (CONS)) \
        else $error(MSG);

// The consequent must hold in the cycle after the antecedent.
`define PMC_ASSERT_NEXT(LBL, CK, RN, ANTE, CONS, MSG) \
    LBL: assert property (@(posedge CK) disable iff (!RN) (ANTE) |=> (CONS)) \
        else $error(MSG);

`endif

// ----- design/pmc_pkg.sv -----
package pmc_pkg;

    // Side length of the square mask store of each sprite.
    localparam int MAX_SIDE = 64;
    localparam int CELLS    = MAX_SIDE * MAX_SIDE;
    localparam int IDX_W    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int ADDR_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int SIZE_W   = $clog2(MAX_SIDE + 1);

    // Fixed field widths of the item and register formats.
    localparam int FUNC_W     = 2;
    localparam int PIX_IDX_W  = 6;
    localparam int PIX_W      = 32;
    localparam int POS_W      = 16;
    localparam int EXT_W      = POS_W + 2;
    localparam int SIDE_CFG_W = 7;
    localparam int KEY_W      = 32;
    localparam int STEP_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Scan counter must hold an offset plus the largest stride.
    localparam int CNT_W = $clog2(MAX_SIDE + 2 ** STEP_W);
    // Load address before truncation: row * MAX_SIDE + col.
    localparam int LD_W  = PIX_IDX_W + SIZE_W + 1;

    localparam logic [SIDE_CFG_W-1:0] SIDE_RST = 7'd64;
    localparam logic [STEP_W-1:0]     STEP_RST = 7'd1;
    localparam logic [KEY_W-1:0]      KEY_RST  = 32'd0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD_A = 2'd0,
        FUNC_LOAD_B = 2'd1,
        FUNC_QUERY  = 2'd2
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_A_WIDTH     = 3'd0,
        REG_A_HEIGHT    = 3'd1,
        REG_B_WIDTH     = 3'd2,
        REG_B_HEIGHT    = 3'd3,
        REG_A_COLOR_KEY = 3'd4,
        REG_B_COLOR_KEY = 3'd5,
        REG_STEP_SKIP   = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BOX,
        S_CLIP,
        S_OFFS,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

endpackage

// ----- design/pmc_cmd_if.sv -----
interface pmc_cmd_if;

    logic                                valid;
    logic                                ready;
    logic [pmc_pkg::FUNC_W-1:0]          func;
    logic [pmc_pkg::PIX_IDX_W-1:0]       pixel_col;
    logic [pmc_pkg::PIX_IDX_W-1:0]       pixel_row;
    logic [pmc_pkg::PIX_W-1:0]           pixel_value;
    logic signed [pmc_pkg::POS_W-1:0]    a_x;
    logic signed [pmc_pkg::POS_W-1:0]    a_y;
    logic signed [pmc_pkg::POS_W-1:0]    b_x;
    logic signed [pmc_pkg::POS_W-1:0]    b_y;

    modport source (
        output valid, func, pixel_col, pixel_row, pixel_value, a_x, a_y, b_x, b_y,
        input  ready
    );

    modport sink (
        input  valid, func, pixel_col, pixel_row, pixel_value, a_x, a_y, b_x, b_y,
        output ready
    );

endinterface

// ----- design/pmc_rsp_if.sv -----
interface pmc_rsp_if;

    logic valid;
    logic ready;
    logic collided;

    modport source (
        output valid, collided,
        input  ready
    );

    modport sink (
        input  valid, collided,
        output ready
    );

endinterface

// ----- design/pmc_ram.sv -----
// Simple dual-port RAM: one write port, one read port with registered data.
module pmc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/pixel_mask_collision_core.sv -----
// Loads (sprite A or B pixel) leave the core ready for the next item.
// A query builds both boxes and clips them; when they meet it scans up to N points,
// N = ceil(w/skip) * ceil(h/skip) over the overlap, up to 4096 for 64x64.
// One mask point is tested per cycle, set by the single read port of each mask RAM.
// rst_n is asynchronous and active low; it clears the sequencer, the result valid flag
// and the configuration registers. The mask RAMs are not cleared and need no sweep.
module pixel_mask_collision_core (
    input  logic                               clk,
    input  logic                               rst_n,
    pmc_cmd_if.sink                            cmd,
    pmc_rsp_if.source                          rsp,
    input  logic                               cfg_we,
    input  logic [pmc_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [pmc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------

    // Sizes above the mask side saturate to the mask side.
    function automatic logic [pmc_pkg::SIZE_W-1:0] clamp_side(
        input logic [pmc_pkg::SIDE_CFG_W-1:0] s
    );
        if (int'(s) > pmc_pkg::MAX_SIDE)
        begin
            clamp_side = pmc_pkg::SIZE_W'(pmc_pkg::MAX_SIDE);
        end
        else
        begin
            clamp_side = pmc_pkg::SIZE_W'(s);
        end
    endfunction

    // Linear mask address of a row and column inside one sprite.
    function automatic logic [pmc_pkg::ADDR_W-1:0] cell_addr(
        input logic [pmc_pkg::IDX_W-1:0] r,
        input logic [pmc_pkg::IDX_W-1:0] c
    );
        cell_addr = pmc_pkg::ADDR_W'(r) * pmc_pkg::ADDR_W'(pmc_pkg::MAX_SIDE)
                  + pmc_pkg::ADDR_W'(c);
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------

    logic [pmc_pkg::SIDE_CFG_W-1:0] a_width_reg;
    logic [pmc_pkg::SIDE_CFG_W-1:0] a_height_reg;
    logic [pmc_pkg::SIDE_CFG_W-1:0] b_width_reg;
    logic [pmc_pkg::SIDE_CFG_W-1:0] b_height_reg;
    logic [pmc_pkg::KEY_W-1:0]      a_color_key_reg;
    logic [pmc_pkg::KEY_W-1:0]      b_color_key_reg;
    logic [pmc_pkg::STEP_W-1:0]     step_skip_reg;

    // Writes must only arrive while the core is idle; the block does not enforce it, and has no shadowing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_width_reg     <= pmc_pkg::SIDE_RST;
            a_height_reg    <= pmc_pkg::SIDE_RST;
            b_width_reg     <= pmc_pkg::SIDE_RST;
            b_height_reg    <= pmc_pkg::SIDE_RST;
            a_color_key_reg <= pmc_pkg::KEY_RST;
            b_color_key_reg <= pmc_pkg::KEY_RST;
            step_skip_reg   <= pmc_pkg::STEP_RST;
        end
        else if (cfg_we)
        begin
            case (pmc_pkg::cfg_reg_t'(cfg_idx))
                pmc_pkg::REG_A_WIDTH:     a_width_reg     <= cfg_data[pmc_pkg::SIDE_CFG_W-1:0];
                pmc_pkg::REG_A_HEIGHT:    a_height_reg    <= cfg_data[pmc_pkg::SIDE_CFG_W-1:0];
                pmc_pkg::REG_B_WIDTH:     b_width_reg     <= cfg_data[pmc_pkg::SIDE_CFG_W-1:0];
                pmc_pkg::REG_B_HEIGHT:    b_height_reg    <= cfg_data[pmc_pkg::SIDE_CFG_W-1:0];
                pmc_pkg::REG_A_COLOR_KEY: a_color_key_reg <= cfg_data[pmc_pkg::KEY_W-1:0];
                pmc_pkg::REG_B_COLOR_KEY: b_color_key_reg <= cfg_data[pmc_pkg::KEY_W-1:0];
                pmc_pkg::REG_STEP_SKIP:   step_skip_reg   <= cfg_data[pmc_pkg::STEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state and datapath registers
    // ------------------------------------------------------------------

    pmc_pkg::state_t state_reg;
    pmc_pkg::state_t state_next;

    // Query positions captured when the item is accepted.
    logic signed [pmc_pkg::POS_W-1:0] ax_reg;
    logic signed [pmc_pkg::POS_W-1:0] ay_reg;
    logic signed [pmc_pkg::POS_W-1:0] bx_reg;
    logic signed [pmc_pkg::POS_W-1:0] by_reg;

    // Far edges of both boxes (inclusive), two bits wider to hold the carry.
    logic signed [pmc_pkg::EXT_W-1:0] ax1_reg;
    logic signed [pmc_pkg::EXT_W-1:0] ay1_reg;
    logic signed [pmc_pkg::EXT_W-1:0] bx1_reg;
    logic signed [pmc_pkg::EXT_W-1:0] by1_reg;
    logic                             empty_reg;
    logic [pmc_pkg::STEP_W-1:0]       stride_reg;

    // Overlap rectangle in screen coordinates.
    logic signed [pmc_pkg::EXT_W-1:0] xs_reg;
    logic signed [pmc_pkg::EXT_W-1:0] xe_reg;
    logic signed [pmc_pkg::EXT_W-1:0] ys_reg;
    logic signed [pmc_pkg::EXT_W-1:0] ye_reg;

    // Overlap origin inside each sprite, and the overlap size.
    logic [pmc_pkg::IDX_W-1:0]  oa_x_reg;
    logic [pmc_pkg::IDX_W-1:0]  oa_y_reg;
    logic [pmc_pkg::IDX_W-1:0]  ob_x_reg;
    logic [pmc_pkg::IDX_W-1:0]  ob_y_reg;
    logic [pmc_pkg::SIZE_W-1:0] w_ov_reg;
    logic [pmc_pkg::SIZE_W-1:0] h_ov_reg;

    // Scan position relative to the overlap origin.
    logic [pmc_pkg::IDX_W-1:0] dx_reg;
    logic [pmc_pkg::IDX_W-1:0] dy_reg;
    logic [pmc_pkg::IDX_W-1:0] dx_next;
    logic [pmc_pkg::IDX_W-1:0] dy_next;

    // A mask read issued last cycle whose data is now at the RAM outputs.
    logic pend_reg;
    logic res_reg;

    // Result register toward the output channel.
    logic rsp_valid_reg;
    logic collided_reg;

    // ------------------------------------------------------------------
    // Combinational datapath
    // ------------------------------------------------------------------

    logic cmd_accept;
    logic [pmc_pkg::SIZE_W-1:0] aw_c;
    logic [pmc_pkg::SIZE_W-1:0] ah_c;
    logic [pmc_pkg::SIZE_W-1:0] bw_c;
    logic [pmc_pkg::SIZE_W-1:0] bh_c;

    logic signed [pmc_pkg::EXT_W-1:0] ax_e;
    logic signed [pmc_pkg::EXT_W-1:0] ay_e;
    logic signed [pmc_pkg::EXT_W-1:0] bx_e;
    logic signed [pmc_pkg::EXT_W-1:0] by_e;
    logic                             overlap;

    logic [pmc_pkg::CNT_W-1:0] nx;
    logic [pmc_pkg::CNT_W-1:0] ny;
    logic                      row_end;
    logic                      last_point;

    logic                        mask_a_bit;
    logic                        mask_b_bit;
    logic                        hit;
    logic                        slot_free;

    logic [pmc_pkg::LD_W-1:0]    ld_full;
    logic                        ld_in_range;
    logic [pmc_pkg::IDX_W-1:0]   ra_row;
    logic [pmc_pkg::IDX_W-1:0]   ra_col;
    logic [pmc_pkg::IDX_W-1:0]   rb_row;
    logic [pmc_pkg::IDX_W-1:0]   rb_col;

    // RAM port signals.
    logic                        we_a;
    logic                        we_b;
    logic                        rd_en;
    logic [pmc_pkg::ADDR_W-1:0]  waddr;
    logic [pmc_pkg::ADDR_W-1:0]  raddr_a;
    logic [pmc_pkg::ADDR_W-1:0]  raddr_b;
    logic                        wdata_a;
    logic                        wdata_b;

    assign cmd_accept = cmd.valid && cmd.ready;

    assign aw_c = clamp_side(a_width_reg);
    assign ah_c = clamp_side(a_height_reg);
    assign bw_c = clamp_side(b_width_reg);
    assign bh_c = clamp_side(b_height_reg);

    assign ax_e = pmc_pkg::EXT_W'(ax_reg);
    assign ay_e = pmc_pkg::EXT_W'(ay_reg);
    assign bx_e = pmc_pkg::EXT_W'(bx_reg);
    assign by_e = pmc_pkg::EXT_W'(by_reg);

    // The boxes meet unless one lies wholly past the other on an axis.
    // An empty sprite never collides.
    assign overlap = !empty_reg
                  && !((bx1_reg < ax_e) || (ax1_reg < bx_e)
                    || (by1_reg < ay_e) || (ay1_reg < by_e));

    // Scan stepping: the one adder pair that runs every scan cycle.
    // A row ends when the next column passes the overlap width; the scan
    // ends when, in addition, the next row passes the overlap height.
    assign nx         = pmc_pkg::CNT_W'(dx_reg) + pmc_pkg::CNT_W'(stride_reg);
    assign ny         = pmc_pkg::CNT_W'(dy_reg) + pmc_pkg::CNT_W'(stride_reg);
    assign row_end    = nx >= pmc_pkg::CNT_W'(w_ov_reg);
    assign last_point = row_end && (ny >= pmc_pkg::CNT_W'(h_ov_reg));
    assign dx_next    = row_end ? '0 : nx[pmc_pkg::IDX_W-1:0];
    assign dy_next    = row_end ? ny[pmc_pkg::IDX_W-1:0] : dy_reg;

    // The scanned point lies inside both sprites, so the sums stay in range.
    assign ra_row = oa_y_reg + dy_reg;
    assign ra_col = oa_x_reg + dx_reg;
    assign rb_row = ob_y_reg + dy_reg;
    assign rb_col = ob_x_reg + dx_reg;

    assign hit       = pend_reg && mask_a_bit && mask_b_bit;
    assign slot_free = !rsp_valid_reg || rsp.ready;

    // Load address; rows and columns outside the mask are dropped.
    assign ld_full = pmc_pkg::LD_W'(cmd.pixel_row) * pmc_pkg::LD_W'(pmc_pkg::MAX_SIDE)
                   + pmc_pkg::LD_W'(cmd.pixel_col);
    assign ld_in_range = (int'(cmd.pixel_col) < pmc_pkg::MAX_SIDE)
                      && (int'(cmd.pixel_row) < pmc_pkg::MAX_SIDE);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pmc_pkg::S_IDLE:
            begin
                if (cmd_accept && (cmd.func == pmc_pkg::FUNC_QUERY))
                begin
                    state_next = pmc_pkg::S_BOX;
                end
            end
            pmc_pkg::S_BOX:
            begin
                state_next = pmc_pkg::S_CLIP;
            end
            pmc_pkg::S_CLIP:
            begin
                state_next = overlap ? pmc_pkg::S_OFFS : pmc_pkg::S_DONE;
            end
            pmc_pkg::S_OFFS:
            begin
                state_next = pmc_pkg::S_SCAN;
            end
            pmc_pkg::S_SCAN:
            begin
                if (hit)
                begin
                    state_next = pmc_pkg::S_DONE;
                end
                else if (last_point)
                begin
                    state_next = pmc_pkg::S_DRAIN;
                end
            end
            pmc_pkg::S_DRAIN:
            begin
                state_next = pmc_pkg::S_DONE;
            end
            pmc_pkg::S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = pmc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pmc_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs of the sequencer
    // ------------------------------------------------------------------

    always_comb
    begin
        cmd.ready = 1'b0;
        rd_en     = 1'b0;
        we_a      = 1'b0;
        we_b      = 1'b0;
        case (state_reg)
            pmc_pkg::S_IDLE:
            begin
                cmd.ready = 1'b1;
                we_a = cmd.valid && ld_in_range && (cmd.func == pmc_pkg::FUNC_LOAD_A);
                we_b = cmd.valid && ld_in_range && (cmd.func == pmc_pkg::FUNC_LOAD_B);
            end
            pmc_pkg::S_SCAN:
            begin
                rd_en = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign waddr   = ld_full[pmc_pkg::ADDR_W-1:0];
    assign wdata_a = cmd.pixel_value != a_color_key_reg;
    assign wdata_b = cmd.pixel_value != b_color_key_reg;
    assign raddr_a = cell_addr(ra_row, ra_col);
    assign raddr_b = cell_addr(rb_row, rb_col);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pmc_pkg::S_IDLE;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // A read is in flight exactly in the cycle after a scan cycle.
            pend_reg  <= (state_reg == pmc_pkg::S_SCAN);
            if ((state_reg == pmc_pkg::S_DONE) && slot_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and working registers carry no reset.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            pmc_pkg::S_IDLE:
            begin
                ax_reg <= cmd.a_x;
                ay_reg <= cmd.a_y;
                bx_reg <= cmd.b_x;
                by_reg <= cmd.b_y;
            end
            pmc_pkg::S_BOX:
            begin
                ax1_reg    <= ax_e + pmc_pkg::EXT_W'(aw_c) - pmc_pkg::EXT_W'(1);
                ay1_reg    <= ay_e + pmc_pkg::EXT_W'(ah_c) - pmc_pkg::EXT_W'(1);
                bx1_reg    <= bx_e + pmc_pkg::EXT_W'(bw_c) - pmc_pkg::EXT_W'(1);
                by1_reg    <= by_e + pmc_pkg::EXT_W'(bh_c) - pmc_pkg::EXT_W'(1);
                empty_reg  <= (aw_c == '0) || (ah_c == '0) || (bw_c == '0) || (bh_c == '0);
                stride_reg <= (step_skip_reg == '0) ? pmc_pkg::STEP_W'(1) : step_skip_reg;
            end
            pmc_pkg::S_CLIP:
            begin
                xs_reg  <= (ax_e > bx_e) ? ax_e : bx_e;
                xe_reg  <= (ax1_reg < bx1_reg) ? ax1_reg : bx1_reg;
                ys_reg  <= (ay_e > by_e) ? ay_e : by_e;
                ye_reg  <= (ay1_reg < by1_reg) ? ay1_reg : by1_reg;
                res_reg <= 1'b0;
            end
            pmc_pkg::S_OFFS:
            begin
                oa_x_reg <= pmc_pkg::IDX_W'(xs_reg - ax_e);
                oa_y_reg <= pmc_pkg::IDX_W'(ys_reg - ay_e);
                ob_x_reg <= pmc_pkg::IDX_W'(xs_reg - bx_e);
                ob_y_reg <= pmc_pkg::IDX_W'(ys_reg - by_e);
                w_ov_reg <= pmc_pkg::SIZE_W'(xe_reg - xs_reg + pmc_pkg::EXT_W'(1));
                h_ov_reg <= pmc_pkg::SIZE_W'(ye_reg - ys_reg + pmc_pkg::EXT_W'(1));
                dx_reg   <= '0;
                dy_reg   <= '0;
            end
            pmc_pkg::S_SCAN:
            begin
                dx_reg  <= dx_next;
                dy_reg  <= dy_next;
                res_reg <= hit;
            end
            pmc_pkg::S_DRAIN:
            begin
                res_reg <= hit;
            end
            pmc_pkg::S_DONE:
            begin
                if (slot_free)
                begin
                    collided_reg <= res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.collided = collided_reg;

    // ------------------------------------------------------------------
    // Mask stores, one opacity bit per pixel
    // ------------------------------------------------------------------

    pmc_ram #(
        .WIDTH (1),
        .DEPTH (pmc_pkg::CELLS)
    ) u_mask_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata_a),
        .re    (rd_en),
        .raddr (raddr_a),
        .rdata (mask_a_bit)
    );

    pmc_ram #(
        .WIDTH (1),
        .DEPTH (pmc_pkg::CELLS)
    ) u_mask_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (wdata_b),
        .re    (rd_en),
        .raddr (raddr_b),
        .rdata (mask_b_bit)
    );

endmodule

// ----- design/pmc_checker.sv -----
`include "pixel_mask_collision_core_assert.svh"

// Port-level checks of the collision core.
module pmc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic [pmc_pkg::FUNC_W-1:0]    cmd_func,
    input logic                          rsp_valid,
    input logic                          rsp_ready
);

    logic cmd_accept;
    logic query_accept;
    logic other_accept;

    assign cmd_accept   = cmd_valid && cmd_ready;
    assign query_accept = cmd_accept && (cmd_func == pmc_pkg::FUNC_QUERY);
    assign other_accept = cmd_accept && (cmd_func != pmc_pkg::FUNC_QUERY);

    // A query occupies the core, so it cannot take another item at once.
    `PMC_ASSERT_NEXT(a_query_busy, clk, rst_n, query_accept, !cmd_ready, "ready after a query item")

    // A load or other non-query item gives no result and leaves the core ready for the next item.
    `PMC_ASSERT_NEXT(a_load_ready, clk, rst_n, other_accept, cmd_ready, "not ready after a load item")

    // A new result only appears at the end of a query, while the core was busy.
    `PMC_ASSERT_SAME(a_rsp_from_query, clk, rst_n, $rose(rsp_valid), $past(!cmd_ready), "result while idle")

    // A pending result stays offered until it is taken.
    `PMC_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid, "result dropped")

endmodule

bind pixel_mask_collision_core pmc_checker u_pmc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .cmd_func  (cmd.func),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready)
);

// ----- verif/tb_pixel_mask_collision_core.sv -----
`timescale 1ns / 100ps

module tb_pixel_mask_collision_core;
    import pmc_pkg::*;

    // Codes that the package leaves unnamed: the spare func code and the spare
    // register index. Both must be ignored by the core.
    localparam logic [FUNC_W-1:0]    FUNC_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    // The limit covers a full 64x64 scan with no hit, a long receiver
    // hold-off and the sender gaps, and leaves several times that sum
    // as margin.
    localparam int STALL_LIMIT   = 25000;
    // Quiet cycles after the last answer, so that the last load has landed
    // before the registers are touched.
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 64;
    localparam int LONG_HOLD     = 400;
    localparam int PHASE_ITEMS   = 200;
    localparam int NUM_PHASES    = 7;
    // Side of the top-left corner of both masks that is written before the
    // first query. The random part keeps every sprite inside it.
    localparam int FILL_SIDE     = 16;

    typedef struct {
        logic [FUNC_W-1:0]       func;
        logic [PIX_IDX_W-1:0]    col;
        logic [PIX_IDX_W-1:0]    row;
        logic [PIX_W-1:0]        value;
        logic signed [POS_W-1:0] a_x;
        logic signed [POS_W-1:0] a_y;
        logic signed [POS_W-1:0] b_x;
        logic signed [POS_W-1:0] b_y;
    } pmc_item_t;

    // How a row of the directed table gets its expected answer: from the
    // predictor, or typed into the table where it is obvious.
    typedef enum { ROW_ITEM, ROW_CFG } row_kind_t;
    typedef enum { OUT_PREDICT, OUT_NONE, OUT_MISS, OUT_HIT } row_out_t;

    typedef struct {
        row_kind_t               kind;
        pmc_item_t               item;
        logic [CFG_IDX_W-1:0]    reg_idx;
        logic [CFG_DATA_W-1:0]   reg_data;
        row_out_t                out;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    pmc_cmd_if cmd ();
    pmc_rsp_if rsp ();

    pixel_mask_collision_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // Shadow copy of the core: both opacity masks and the register file.
    bit                    opaque_a [CELLS];
    bit                    opaque_b [CELLS];
    logic [SIDE_CFG_W-1:0] a_wide;
    logic [SIDE_CFG_W-1:0] a_tall;
    logic [SIDE_CFG_W-1:0] b_wide;
    logic [SIDE_CFG_W-1:0] b_tall;
    logic [KEY_W-1:0]      a_key;
    logic [KEY_W-1:0]      b_key;
    logic [STEP_W-1:0]     stride_cfg;

    // Collision answers still owed by the core, oldest first.
    bit expected_hits [$];

    int errors;
    int quiet_cycles;
    int snd_idle_pct;
    int rcv_idle_pct;
    bit hold_request;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sides above the mask size saturate; zero stays zero (empty sprite).
    function automatic int side_clamp(logic [SIDE_CFG_W-1:0] s);
        return (s > MAX_SIDE) ? MAX_SIDE : int'(s);
    endfunction

    // Expected answer of one query: reject on disjoint boxes, otherwise walk
    // the overlap with the stride and stop at the first doubly opaque point.
    function automatic bit opaque_overlap(int ax, int ay, int bx, int by);
        int aw, ah, bw, bh, stride;
        int xs, xe, ys, ye, ia, ib;
        aw = side_clamp(a_wide);
        ah = side_clamp(a_tall);
        bw = side_clamp(b_wide);
        bh = side_clamp(b_tall);
        stride = (stride_cfg == 0) ? 1 : int'(stride_cfg);
        if (aw == 0 || ah == 0 || bw == 0 || bh == 0)
            return 1'b0;
        if (bx + bw - 1 < ax || ax + aw - 1 < bx || by + bh - 1 < ay || ay + ah - 1 < by)
            return 1'b0;
        xs = (ax > bx) ? ax : bx;
        xe = (ax + aw < bx + bw) ? ax + aw - 1 : bx + bw - 1;
        ys = (ay > by) ? ay : by;
        ye = (ay + ah < by + bh) ? ay + ah - 1 : by + bh - 1;
        for (int y = ys; y <= ye; y += stride)
        begin
            for (int x = xs; x <= xe; x += stride)
            begin
                ia = (y - ay) * MAX_SIDE + (x - ax);
                ib = (y - by) * MAX_SIDE + (x - bx);
                if (ia >= 0 && ia < CELLS && ib >= 0 && ib < CELLS && opaque_a[ia] && opaque_b[ib])
                    return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Applies one taken item to the shadow state and queues its answer.
    function automatic void track_item(pmc_item_t it, row_out_t out);
        bit hit;
        int mask_idx;
        mask_idx = int'(it.row) * MAX_SIDE + int'(it.col);
        case (it.func)
            FUNC_LOAD_A: opaque_a[mask_idx] = (it.value != a_key);
            FUNC_LOAD_B: opaque_b[mask_idx] = (it.value != b_key);
            FUNC_QUERY:
            begin
                hit = opaque_overlap(int'(it.a_x), int'(it.a_y), int'(it.b_x), int'(it.b_y));
                if (out == OUT_HIT)
                    hit = 1'b1;
                else if (out == OUT_MISS)
                    hit = 1'b0;
                expected_hits.push_back(hit);
            end
            default: ;
        endcase
    endfunction

    // A pixel word that is never equal to the given key.
    function automatic logic [PIX_W-1:0] opaque_word(logic [KEY_W-1:0] key);
        return key ^ ($urandom | 32'd1);
    endfunction

    // Fields that an item does not use are filled with noise.
    function automatic pmc_item_t make_item(logic [FUNC_W-1:0] func, int col, int row,
                                            logic [PIX_W-1:0] value);
        pmc_item_t it;
        it.func  = func;
        it.col   = col[PIX_IDX_W-1:0];
        it.row   = row[PIX_IDX_W-1:0];
        it.value = value;
        it.a_x   = POS_W'($urandom);
        it.a_y   = POS_W'($urandom);
        it.b_x   = POS_W'($urandom);
        it.b_y   = POS_W'($urandom);
        return it;
    endfunction

    function automatic pmc_item_t make_query(int ax, int ay, int bx, int by);
        pmc_item_t it;
        it = make_item(FUNC_QUERY, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
        it.a_x = ax[POS_W-1:0];
        it.a_y = ay[POS_W-1:0];
        it.b_x = bx[POS_W-1:0];
        it.b_y = by[POS_W-1:0];
        return it;
    endfunction

    function automatic stim_row_t item_row(pmc_item_t it, row_out_t out);
        stim_row_t r;
        r.kind     = ROW_ITEM;
        r.item     = it;
        r.reg_idx  = REG_UNMAPPED;
        r.reg_data = '0;
        r.out      = out;
        return r;
    endfunction

    function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        stim_row_t r;
        r.kind     = ROW_CFG;
        r.item     = make_item(FUNC_UNUSED, 0, 0, '0);
        r.reg_idx  = idx;
        r.reg_data = data;
        r.out      = OUT_NONE;
        return r;
    endfunction

    // Positions cluster near the origin and near both ends of the 16-bit range, or spread over all of it.
    function automatic int rand_coord();
        case ($urandom_range(0, 3))
            0:       return int'($urandom_range(0, 200)) - 100;
            1:       return int'($urandom_range(0, 65535)) - 32768;
            2:       return 32767 - int'($urandom_range(0, 40));
            default: return -32768 + int'($urandom_range(0, 40));
        endcase
    endfunction

    // Size of the mask area that the current sprite size can reach, at least one.
    function automatic int paint_span(logic [SIDE_CFG_W-1:0] s);
        int v;
        v = side_clamp(s);
        return (v < 1) ? 1 : v;
    endfunction

    // A 7-bit register value, now and then with junk above bit 6.
    function automatic logic [CFG_DATA_W-1:0] reg7(logic [SIDE_CFG_W-1:0] v);
        logic [CFG_DATA_W-SIDE_CFG_W-1:0] junk;
        junk = ($urandom_range(0, 3) == 0) ? (CFG_DATA_W - SIDE_CFG_W)'($urandom) : '0;
        return {junk, v};
    endfunction

    // Sprite sizes stay inside the written corner; zero gives an empty sprite.
    function automatic logic [SIDE_CFG_W-1:0] wild_side();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return SIDE_CFG_W'(FILL_SIDE);
            default: return SIDE_CFG_W'($urandom_range(1, 10));
        endcase
    endfunction

    // Offers one item, waits until the core takes it, and books it. Called
    // and returning at a falling edge, so valid is touched once per step.
    task automatic send_cmd(pmc_item_t it, row_out_t out);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            cmd.valid = 1'b0;
            @(negedge clk);
        end
        cmd.valid       = 1'b1;
        cmd.func        = it.func;
        cmd.pixel_col   = it.col;
        cmd.pixel_row   = it.row;
        cmd.pixel_value = it.value;
        cmd.a_x         = it.a_x;
        cmd.a_y         = it.a_y;
        cmd.b_x         = it.b_x;
        cmd.b_y         = it.b_y;
        do
            @(posedge clk);
        while (!cmd.ready);
        track_item(it, out);
        @(negedge clk);
    endtask

    // Holds the write enable across back-to-back writes and drops it after
    // the last one of a burst.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data, bit last);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge clk);
        if (last)
            cfg_we = 1'b0;
        case (idx)
            REG_A_WIDTH:     a_wide     = data[SIDE_CFG_W-1:0];
            REG_A_HEIGHT:    a_tall     = data[SIDE_CFG_W-1:0];
            REG_B_WIDTH:     b_wide     = data[SIDE_CFG_W-1:0];
            REG_B_HEIGHT:    b_tall     = data[SIDE_CFG_W-1:0];
            REG_A_COLOR_KEY: a_key      = data[KEY_W-1:0];
            REG_B_COLOR_KEY: b_key      = data[KEY_W-1:0];
            REG_STEP_SKIP:   stride_cfg = data[STEP_W-1:0];
            default: ;
        endcase
    endtask

    // Stops offering items until every answer is in and the last load has
    // certainly landed.
    task automatic wait_idle();
        cmd.valid = 1'b0;
        while (expected_hits.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes a pixel inside the area that the current sprite size reaches,
    // transparent with the given odds.
    task automatic send_paint(bit to_b, int clear_pct);
        logic [KEY_W-1:0] key;
        int w, h;
        w   = paint_span(to_b ? b_wide : a_wide);
        h   = paint_span(to_b ? b_tall : a_tall);
        key = to_b ? b_key : a_key;
        send_cmd(make_item(to_b ? FUNC_LOAD_B : FUNC_LOAD_A,
                           $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                           ($urandom_range(0, 99) < clear_pct) ? key : opaque_word(key)),
                 OUT_NONE);
    endtask

    // A query whose boxes mostly overlap: B is placed within reach of A.
    task automatic send_probe();
        int aw, ah, bw, bh, ax, ay, bx, by;
        aw = paint_span(a_wide);
        ah = paint_span(a_tall);
        bw = paint_span(b_wide);
        bh = paint_span(b_tall);
        ax = rand_coord();
        ay = rand_coord();
        bx = ax + int'($urandom_range(0, aw + bw)) - bw;
        by = ay + int'($urandom_range(0, ah + bh)) - bh;
        send_cmd(make_query(ax, ay, bx, by), OUT_PREDICT);
    endtask

    // The directed table. Expected answers are typed in where they are plain
    // to see; every mask bit that a row looks at is opaque when it starts.
    task automatic build_directed(ref stim_row_t rows [$]);
        // Full overlap, then the far corners of the coordinate range.
        rows.push_back(item_row(make_query(0, 0, 0, 0), OUT_HIT));
        rows.push_back(item_row(make_query(-32768, -32768, 32767, 32767), OUT_MISS));
        rows.push_back(item_row(make_query(32767, 32767, 32767, 32767), OUT_HIT));
        rows.push_back(item_row(make_query(-32768, 32767, -32705, 32767), OUT_HIT));
        // Boxes that just touch versus boxes that share one corner pixel.
        rows.push_back(item_row(make_query(0, 0, 64, 0), OUT_MISS));
        rows.push_back(item_row(make_query(0, 0, 63, 63), OUT_HIT));
        // The spare func code and the spare register index do nothing.
        rows.push_back(item_row(make_item(FUNC_UNUSED, 5, 9, 32'hFFFF_FFFF), OUT_NONE));
        rows.push_back(reg_row(REG_UNMAPPED, 32'hFFFF_FFFF));
        rows.push_back(item_row(make_query(0, 0, 0, 0), OUT_PREDICT));
        // An empty sprite never collides.
        rows.push_back(reg_row(REG_A_WIDTH, 32'd0));
        rows.push_back(item_row(make_query(0, 0, 0, 0), OUT_MISS));
        // An oversized width saturates at the mask size.
        rows.push_back(reg_row(REG_A_WIDTH, 32'hFFFF_FF7F));
        rows.push_back(item_row(make_query(0, 0, 63, 0), OUT_HIT));
        rows.push_back(item_row(make_query(0, 0, 64, 0), OUT_MISS));
        // A zero stride walks like a stride of one.
        rows.push_back(reg_row(REG_STEP_SKIP, 32'd0));
        rows.push_back(item_row(make_query(0, 0, 0, 0), OUT_HIT));
        // Single-pixel sprites on top of each other.
        rows.push_back(reg_row(REG_A_WIDTH, 32'd1));
        rows.push_back(reg_row(REG_A_HEIGHT, 32'd1));
        rows.push_back(reg_row(REG_B_WIDTH, 32'd1));
        rows.push_back(reg_row(REG_B_HEIGHT, 32'd1));
        rows.push_back(item_row(make_item(FUNC_LOAD_A, 0, 0, 32'd0), OUT_NONE));
        rows.push_back(item_row(make_query(5, 5, 5, 5), OUT_MISS));
        rows.push_back(item_row(make_item(FUNC_LOAD_A, 0, 0, 32'hFFFF_FFFF), OUT_NONE));
        // A key written after a load leaves the stored opacity alone.
        rows.push_back(reg_row(REG_A_COLOR_KEY, 32'hFFFF_FFFF));
        rows.push_back(item_row(make_query(-1, -1, -1, -1), OUT_HIT));
        rows.push_back(item_row(make_item(FUNC_LOAD_A, 0, 0, 32'hFFFF_FFFF), OUT_NONE));
        rows.push_back(item_row(make_query(-1, -1, -1, -1), OUT_MISS));
        // Full-size sprites with a stride beyond the side: only the top-left
        // point of the overlap is looked at.
        rows.push_back(item_row(make_item(FUNC_LOAD_A, 0, 0, 32'd0), OUT_NONE));
        rows.push_back(item_row(make_item(FUNC_LOAD_B, 63, 63, 32'd0), OUT_NONE));
        rows.push_back(reg_row(REG_A_WIDTH, 32'd64));
        rows.push_back(reg_row(REG_A_HEIGHT, 32'd64));
        rows.push_back(reg_row(REG_B_WIDTH, 32'd64));
        rows.push_back(reg_row(REG_B_HEIGHT, 32'd64));
        rows.push_back(reg_row(REG_STEP_SKIP, 32'd127));
        rows.push_back(item_row(make_query(0, 0, 0, 0), OUT_HIT));
        rows.push_back(item_row(make_query(0, 0, -63, -63), OUT_MISS));
    endtask

    // Receiver: takes results with random gaps, and once holds off for a
    // long stretch so that the core backs up into its input.
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                rsp.ready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_request = 1'b0;
            end
            else
                rsp.ready = ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // Result checker and activity counter for the watchdog.
    always @(posedge clk)
    begin
        bit want;
        if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (rsp.valid && rsp.ready)
        begin
            if (expected_hits.size() == 0)
            begin
                $display("%0t: result with no query waiting: expected none, actual collided=%0b",
                         $time, rsp.collided);
                errors = errors + 1;
            end
            else
            begin
                want = expected_hits.pop_front();
                if (rsp.collided !== want)
                begin
                    $display("%0t: collided mismatch: expected %0b, actual %0b",
                             $time, want, rsp.collided);
                    errors = errors + 1;
                end
            end
        end
    end

    // Watchdog: too long without any item moving on either side.
    initial
    begin
        do
            @(negedge clk);
        while (quiet_cycles < STALL_LIMIT);
        $display("pixel_mask_collision_core regression: fail");
        $finish;
    end

    initial
    begin
        stim_row_t rows [$];
        logic [SIDE_CFG_W-1:0] aw, ah, bw, bh, sk;
        int sent;
        int clear_pct;
        bit paused;

        errors       = 0;
        quiet_cycles = 0;
        hold_request = 1'b0;
        snd_idle_pct = 14;
        rcv_idle_pct = 78;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = REG_A_WIDTH;
        cfg_data        = '0;
        cmd.valid       = 1'b0;
        cmd.func        = FUNC_LOAD_A;
        cmd.pixel_col   = '0;
        cmd.pixel_row   = '0;
        cmd.pixel_value = '0;
        cmd.a_x         = '0;
        cmd.a_y         = '0;
        cmd.b_x         = '0;
        cmd.b_y         = '0;

        a_wide     = SIDE_RST;
        a_tall     = SIDE_RST;
        b_wide     = SIDE_RST;
        b_tall     = SIDE_RST;
        a_key      = KEY_RST;
        b_key      = KEY_RST;
        stride_cfg = STEP_RST;
        for (int i = 0; i < CELLS; i++)
        begin
            opaque_a[i] = 1'b0;
            opaque_b[i] = 1'b0;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The masks come out of reset undefined. The corner that the random
        // part works in, and the two far pixels of A that the directed table
        // looks at, are written opaque before any query can read them.
        for (int r = 0; r < FILL_SIDE; r++)
        begin
            for (int c = 0; c < FILL_SIDE; c++)
            begin
                send_cmd(make_item(FUNC_LOAD_A, c, r, opaque_word(a_key)), OUT_NONE);
                send_cmd(make_item(FUNC_LOAD_B, c, r, opaque_word(b_key)), OUT_NONE);
            end
        end
        send_cmd(make_item(FUNC_LOAD_A, MAX_SIDE - 1, 0, opaque_word(a_key)), OUT_NONE);
        send_cmd(make_item(FUNC_LOAD_A, MAX_SIDE - 1, MAX_SIDE - 1, opaque_word(a_key)),
                 OUT_NONE);

        // Directed table, register rows only once the core has gone quiet.
        build_directed(rows);
        for (int r = 0; r < rows.size(); r++)
        begin
            if (rows[r].kind == ROW_CFG)
            begin
                if (r == 0 || rows[r - 1].kind != ROW_CFG)
                    wait_idle();
                write_reg(rows[r].reg_idx, rows[r].reg_data,
                          (r + 1 == rows.size()) || (rows[r + 1].kind != ROW_CFG));
            end
            else
                send_cmd(rows[r].item, rows[r].out);
        end

        // Random phases, each with its own register setting. Most of the
        // traffic repaints the reachable corner of the masks and then probes
        // it with overlapping boxes; the rest is noise.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            if (p < 2)
            begin
                snd_idle_pct = 14;
                rcv_idle_pct = 78;
            end
            else if (p < 4)
            begin
                snd_idle_pct = 78;
                rcv_idle_pct = 14;
            end
            else
            begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            case (p)
                0:
                begin
                    aw = SIDE_CFG_W'($urandom_range(1, 8));
                    ah = SIDE_CFG_W'($urandom_range(1, 8));
                    bw = SIDE_CFG_W'($urandom_range(1, 8));
                    bh = SIDE_CFG_W'($urandom_range(1, 8));
                    sk = STEP_W'(1);
                end
                1:
                begin
                    aw = SIDE_CFG_W'(FILL_SIDE);
                    ah = SIDE_CFG_W'(FILL_SIDE);
                    bw = SIDE_CFG_W'(FILL_SIDE);
                    bh = SIDE_CFG_W'(FILL_SIDE);
                    sk = STEP_W'(FILL_SIDE);
                end
                2:
                begin
                    aw = SIDE_CFG_W'($urandom_range(1, 12));
                    ah = SIDE_CFG_W'($urandom_range(1, 12));
                    bw = SIDE_CFG_W'($urandom_range(1, 12));
                    bh = SIDE_CFG_W'($urandom_range(1, 12));
                    sk = STEP_W'($urandom_range(1, 4));
                end
                3:
                begin
                    aw = SIDE_CFG_W'(1);
                    ah = SIDE_CFG_W'(1);
                    bw = SIDE_CFG_W'(1);
                    bh = SIDE_CFG_W'(1);
                    sk = '0;
                end
                4:
                begin
                    aw = SIDE_CFG_W'($urandom_range(1, FILL_SIDE));
                    ah = SIDE_CFG_W'($urandom_range(1, FILL_SIDE));
                    bw = SIDE_CFG_W'($urandom_range(1, FILL_SIDE));
                    bh = SIDE_CFG_W'($urandom_range(1, FILL_SIDE));
                    sk = STEP_W'(2);
                end
                5:
                begin
                    aw = SIDE_CFG_W'(FILL_SIDE);
                    ah = SIDE_CFG_W'(FILL_SIDE);
                    bw = SIDE_CFG_W'($urandom_range(1, 8));
                    bh = SIDE_CFG_W'($urandom_range(1, 8));
                    sk = STEP_W'(1);
                end
                default:
                begin
                    aw = wild_side();
                    ah = wild_side();
                    bw = wild_side();
                    bh = wild_side();
                    sk = ($urandom_range(0, 3) == 0) ? STEP_W'($urandom_range(0, 127))
                                                     : STEP_W'($urandom_range(0, 3));
                end
            endcase
            write_reg(REG_A_WIDTH, reg7(aw), 1'b0);
            write_reg(REG_A_HEIGHT, reg7(ah), 1'b0);
            write_reg(REG_B_WIDTH, reg7(bw), 1'b0);
            write_reg(REG_B_HEIGHT, reg7(bh), 1'b0);
            write_reg(REG_A_COLOR_KEY, $urandom, 1'b0);
            write_reg(REG_B_COLOR_KEY, $urandom, 1'b0);
            write_reg(REG_STEP_SKIP, reg7(sk), 1'b1);

            // With no idling on either side, the receiver stalls for a long
            // while as the sender keeps offering items.
            if (p == 4)
                hold_request = 1'b1;

            clear_pct = $urandom_range(55, 85);
            sent      = 0;
            paused    = 1'b0;
            while (sent < PHASE_ITEMS)
            begin
                // Once, the sender goes quiet until every answer is back.
                if (p == 2 && !paused && sent >= PHASE_ITEMS / 2)
                begin
                    cmd.valid = 1'b0;
                    while (expected_hits.size() != 0)
                        @(negedge clk);
                    paused = 1'b1;
                end
                if ($urandom_range(0, 3) != 0)
                begin
                    repeat ($urandom_range(0, 6))
                    begin
                        send_paint($urandom_range(0, 1), clear_pct);
                        sent = sent + 1;
                    end
                    repeat ($urandom_range(1, 3))
                    begin
                        send_probe();
                        sent = sent + 1;
                    end
                end
                else
                begin
                    case ($urandom_range(0, 2))
                        0:
                            send_cmd(make_item(FUNC_UNUSED, $urandom_range(0, 63),
                                               $urandom_range(0, 63), $urandom), OUT_NONE);
                        1:
                        begin
                            send_cmd(make_item($urandom_range(0, 1) ? FUNC_LOAD_B : FUNC_LOAD_A,
                                               $urandom_range(0, 63), $urandom_range(0, 63),
                                               $urandom), OUT_NONE);
                            sent = sent + 1;
                        end
                        default:
                        begin
                            send_cmd(make_query(rand_coord(), rand_coord(), rand_coord(),
                                                rand_coord()), OUT_PREDICT);
                            sent = sent + 1;
                        end
                    endcase
                end
            end
        end

        // Let the last answers drain, then watch for strays.
        cmd.valid = 1'b0;
        while (expected_hits.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("pixel_mask_collision_core regression: pass");
        else
            $display("pixel_mask_collision_core regression: fail");
        $finish;
    end

endmodule

// ----- pixel_mask_collision_core.f -----
+incdir+design
design/pmc_pkg.sv
design/pmc_cmd_if.sv
design/pmc_rsp_if.sv
design/pmc_ram.sv
design/pixel_mask_collision_core.sv
design/pmc_checker.sv
verif/tb_pixel_mask_collision_core.sv
